FILE: rtl/envcrc_pkg.sv
// Shared types, codes and the byte-wide CRC-32 step for the environment block checker.
// No dependencies.
`default_nettype none

package envcrc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  localparam logic [16:0] SIZE_MIN = 17'd8;
  localparam logic [16:0] SIZE_MAX = 17'd65536;
  localparam logic [16:0] SIZE_RST = 17'd8192;

  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_EQ  = 8'h3D;
  localparam logic [7:0] CHR_FF  = 8'hFF;
  localparam logic [7:0] FLAG_HI = 8'h01;

  // configuration register indexes
  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_HEADER_MODE = 1'b1;

  // header modes; the unused code acts as auto
  localparam logic [1:0] HM_AUTO = 2'd0;
  localparam logic [1:0] HM_FOUR = 2'd1;
  localparam logic [1:0] HM_FIVE = 2'd2;

  // byte roles
  localparam logic [2:0] ROLE_CRC      = 3'd0;
  localparam logic [2:0] ROLE_FLAG     = 3'd1;
  localparam logic [2:0] ROLE_KEY      = 3'd2;
  localparam logic [2:0] ROLE_EQUALS   = 3'd3;
  localparam logic [2:0] ROLE_VALUE    = 3'd4;
  localparam logic [2:0] ROLE_PAIR_END = 3'd5;
  localparam logic [2:0] ROLE_LIST_END = 3'd6;
  localparam logic [2:0] ROLE_IGNORED  = 3'd7;

  // parse status codes
  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_NO_EQ    = 3'd2;
  localparam logic [2:0] ST_EQ_NUL   = 3'd3;
  localparam logic [2:0] ST_NO_END   = 3'd4;
  localparam logic [2:0] ST_BLANK    = 3'd5;

  localparam logic [15:0] PAIRS_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_KEY   = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_NUL   = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // reflected CRC-32, one byte, eight bit steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/env_block_crc_check_and_parse.sv
// Environment block checker: one byte in, one registered result out.
// Throughput is one byte per cycle while the output is not held; the CRC byte step, header decode and parser
// all sit between the block state and the single output register.
// A new byte is taken while the output register is empty or being drained.
// Synchronous active-high reset: block state cleared, block_bytes 8192, header_mode auto.
// Uses envcrc_pkg.
`default_nettype none

module env_block_crc_check_and_parse
  import envcrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] pair_end, [16:1] pair_count, [19:17] parse_status, [27:20] flag_value,
  // [28] crc_match, [31:29] zero
  output logic [31:0]      m_tdata,
  output logic [2:0]       m_tuser,   // [2:0] byte_role
  output logic             m_tlast,   // block_last
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);

  logic [16:0] block_bytes;
  logic [1:0]  header_mode;

  logic [16:0] pos;
  logic [31:0] crc;
  logic [31:0] stored;
  phase_t      phase;
  logic [2:0]  status;
  logic [7:0]  flag;
  logic [15:0] pairs;
  logic        all_ones;

  logic [16:0] size;
  logic [17:0] pos_inc;
  logic        last;
  logic        is_flag;
  logic        do_parse;
  logic        all_ones_next;
  logic [31:0] crc_next;
  logic [31:0] stored_next;
  phase_t      phase_next;
  logic [2:0]  status_next;
  logic [7:0]  flag_next;
  logic [15:0] pairs_next;
  logic [2:0]  role;
  logic        ended;
  logic        match;
  logic        s_fire;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    if (block_bytes < SIZE_MIN) begin
      size = SIZE_MIN;
    end else if (block_bytes > SIZE_MAX) begin
      size = SIZE_MAX;
    end else begin
      size = block_bytes;
    end
    pos_inc = {1'b0, pos} + 18'd1;
    last    = pos_inc >= {1'b0, size};

    all_ones_next = all_ones && !((pos < 17'd5) && (s_tdata != CHR_FF));
    is_flag = (header_mode == HM_FIVE) ||
              ((header_mode != HM_FOUR) && (s_tdata <= FLAG_HI));

    stored_next = stored;
    crc_next    = crc;
    phase_next  = phase;
    status_next = status;
    flag_next   = flag;
    pairs_next  = pairs;
    role        = ROLE_IGNORED;
    ended       = 1'b0;
    do_parse    = 1'b0;
    match       = 1'b0;

    if (pos < 17'd4) begin
      stored_next = {stored[23:0], s_tdata};
      role        = ROLE_CRC;
    end else if (pos == 17'd4) begin
      if (all_ones_next) begin
        status_next = ST_BLANK;
      end
      if (is_flag) begin
        flag_next = s_tdata;
        role      = ROLE_FLAG;
      end else begin
        do_parse = 1'b1;
      end
    end else begin
      do_parse = 1'b1;
    end

    if (do_parse) begin
      crc_next = crc_byte(crc, s_tdata);
      if (status_next == ST_RUNNING) begin
        case (phase)
          PH_KEY: begin
            if (s_tdata == CHR_NUL) begin
              status_next = ST_NO_EQ;
              phase_next  = PH_DONE;
            end else if (s_tdata == CHR_EQ) begin
              phase_next = PH_VALUE;
              role       = ROLE_EQUALS;
            end else begin
              role = ROLE_KEY;
            end
          end
          PH_VALUE: begin
            if (s_tdata == CHR_NUL) begin
              phase_next = PH_NUL;
              ended      = 1'b1;
              role       = ROLE_PAIR_END;
              if (pairs != PAIRS_MAX) begin
                pairs_next = pairs + 16'd1;
              end
            end else begin
              role = ROLE_VALUE;
            end
          end
          PH_NUL: begin
            if (s_tdata == CHR_NUL) begin
              status_next = ST_OK;
              phase_next  = PH_DONE;
              role        = ROLE_LIST_END;
            end else if (s_tdata == CHR_EQ) begin
              status_next = ST_EQ_NUL;
              phase_next  = PH_DONE;
            end else begin
              phase_next = PH_KEY;
              role       = ROLE_KEY;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end

    if (last) begin
      if (status_next == ST_RUNNING) begin
        status_next = ST_NO_END;
      end
      match = (crc_next ^ CRC_ALL_ONES) == stored_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= SIZE_RST;
      header_mode <= HM_AUTO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_BYTES: block_bytes <= cfg_data;
        REG_HEADER_MODE: header_mode <= cfg_data[1:0];
        default:         block_bytes <= block_bytes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 17'd0;
      crc      <= CRC_ALL_ONES;
      stored   <= 32'd0;
      phase    <= PH_KEY;
      status   <= ST_RUNNING;
      flag     <= 8'd0;
      pairs    <= 16'd0;
      all_ones <= 1'b1;
    end else if (s_fire) begin
      if (last) begin
        // block done, next item is byte 0 of a new block
        pos      <= 17'd0;
        crc      <= CRC_ALL_ONES;
        stored   <= 32'd0;
        phase    <= PH_KEY;
        status   <= ST_RUNNING;
        flag     <= 8'd0;
        pairs    <= 16'd0;
        all_ones <= 1'b1;
      end else begin
        pos      <= pos_inc[16:0];
        crc      <= crc_next;
        stored   <= stored_next;
        phase    <= phase_next;
        status   <= status_next;
        flag     <= flag_next;
        pairs    <= pairs_next;
        all_ones <= all_ones_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {3'd0, match, flag_next, status_next, pairs_next, ended};
      m_tuser <= role;
      m_tlast <= last;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < SIZE_MAX)
    else $error("byte position ran past the largest block");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (s_fire && last) |=> (pos == 17'd0 && crc == CRC_ALL_ONES && pairs == 16'd0))
    else $error("block state not cleared after last byte");

  a_pair_role: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tuser == ROLE_PAIR_END))
    else $error("pair end flagged on a byte that is not a pair end");

  a_crc_running: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ROLE_CRC) |-> (m_tdata[19:17] == ST_RUNNING && !m_tlast))
    else $error("header CRC byte carries a final status");

  a_match_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[28]) |-> m_tlast)
    else $error("crc match reported before the last byte");
`endif

endmodule

`default_nettype wire
